[hw/rtl/mfm_track_format_stream_generator_macros.svh]
// Assertion helpers for the track format stream generator.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef MFM_TRACK_FORMAT_STREAM_GENERATOR_MACROS_SVH
`define MFM_TRACK_FORMAT_STREAM_GENERATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MFMTFG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfmtfg assertion failed");

// Check that cons holds in the cycle after ante.
`define MFMTFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfmtfg assertion failed");

`endif

[hw/rtl/mfmtfg_pkg.sv]
`default_nettype none
package mfmtfg_pkg;

  localparam int TRACK_LEN_BITS_DEF = 16;
  localparam int CFG_AW             = 3;
  localparam int QDEPTH             = 2;
  localparam int WANT_W             = 11;

  localparam logic [15:0] TRACK_LEN_RST = 16'd10416;

  // Register indexes, taken from paddr[2]
  localparam logic REG_GAP_LEVEL = 1'b0;
  localparam logic REG_TRACK_LEN = 1'b1;

  // Stream bytes
  localparam logic [7:0] BYTE_SYNC = 8'h00;
  localparam logic [7:0] BYTE_MCLK = 8'hF5;
  localparam logic [7:0] BYTE_IDAM = 8'hFE;
  localparam logic [7:0] BYTE_DAM  = 8'hFB;
  localparam logic [7:0] BYTE_CRC  = 8'hF7;
  localparam logic [7:0] BYTE_GAP  = 8'h4E;
  localparam logic [7:0] BYTE_FILL = 8'hE5;

  // Room needed before the ID mark and before the data mark
  localparam int ID_ROOM   = 9;
  localparam int DATA_ROOM = 4;

  typedef struct packed {
    logic       is_finish;
    logic [7:0] cylinder;
    logic [7:0] head;
    logic [7:0] record;
    logic [7:0] size_code;
    logic       no_data;
  } mfmtfg_item_t;

  // Level three behaves as level two.
  function automatic logic [1:0] eff_level(input logic [1:0] lvl);
    eff_level = (lvl == 2'd3) ? 2'd2 : lvl;
  endfunction

  function automatic logic [WANT_W-1:0] pregap_len(input logic [1:0] lvl);
    case (lvl)
      2'd0:    pregap_len = WANT_W'(32);
      2'd1:    pregap_len = WANT_W'(24);
      default: pregap_len = WANT_W'(20);
    endcase
  endfunction

  function automatic logic [WANT_W-1:0] sync_len(input logic [1:0] lvl);
    case (lvl)
      2'd0:    sync_len = WANT_W'(12);
      2'd1:    sync_len = WANT_W'(10);
      default: sync_len = WANT_W'(9);
    endcase
  endfunction

  function automatic logic [WANT_W-1:0] gap2_len(input logic [1:0] lvl);
    case (lvl)
      2'd0:    gap2_len = WANT_W'(8'h16);
      2'd1:    gap2_len = WANT_W'(8'h10);
      default: gap2_len = WANT_W'(8'h0C);
    endcase
  endfunction

  function automatic logic [WANT_W-1:0] gap3_len(input logic [1:0] lvl);
    case (lvl)
      2'd0:    gap3_len = WANT_W'(8'h36);
      2'd1:    gap3_len = WANT_W'(8'h30);
      default: gap3_len = WANT_W'(8'h26);
    endcase
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mfmtfg_front.sv]
`default_nettype none
module mfmtfg_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [7:0]               in_cylinder,
  input  logic [7:0]               in_head,
  input  logic [7:0]               in_record,
  input  logic [7:0]               in_size_code,
  input  logic                     in_no_data,
  output logic                     q_valid,
  input  logic                     q_ready,
  output mfmtfg_pkg::mfmtfg_item_t q_item
);
  import mfmtfg_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  mfmtfg_item_t             mem_r [QDEPTH];
  mfmtfg_item_t             item_in;
  logic [PTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     push, pop;

  // Classify the item on the way in
  assign item_in = '{is_finish: in_command, cylinder: in_cylinder, head: in_head,
                     record: in_record, size_code: in_size_code, no_data: in_no_data};

  assign in_ready = (cnt_r != CNT_W'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/mfmtfg_back.sv]
`default_nettype none
module mfmtfg_back #(
  parameter int TRACK_LEN_BITS = mfmtfg_pkg::TRACK_LEN_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               gap_level,
  input  logic [15:0]              track_length,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  mfmtfg_pkg::mfmtfg_item_t q_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_fill_byte,
  output logic [15:0]              out_run_length,
  output logic                     out_last_of_track,
  output logic                     out_overflow
);
  import mfmtfg_pkg::*;

  localparam int PW = TRACK_LEN_BITS;
  localparam int EW = (PW > 16) ? PW : 16;

  // Sequencer steps, one run each
  localparam logic [3:0] ST_PREGAP = 4'd0;
  localparam logic [3:0] ST_SYNC   = 4'd1;
  localparam logic [3:0] ST_MCLK1  = 4'd2;
  localparam logic [3:0] ST_IDAM   = 4'd3;
  localparam logic [3:0] ST_CYL    = 4'd4;
  localparam logic [3:0] ST_HEAD   = 4'd5;
  localparam logic [3:0] ST_REC    = 4'd6;
  localparam logic [3:0] ST_SIZE   = 4'd7;
  localparam logic [3:0] ST_CRC1   = 4'd8;
  localparam logic [3:0] ST_GAP2   = 4'd9;
  localparam logic [3:0] ST_MCLK2  = 4'd10;
  localparam logic [3:0] ST_DAM    = 4'd11;
  localparam logic [3:0] ST_FILL   = 4'd12;
  localparam logic [3:0] ST_CRC2   = 4'd13;
  localparam logic [3:0] ST_GAP3   = 4'd14;

  mfmtfg_item_t      item_r;
  logic              busy_r;
  logic [3:0]        step_r;
  logic [PW-1:0]     pos_r;
  logic              pregap_done_r, ovf_r;
  logic              out_valid_r, out_last_r, out_ovf_r;
  logic [7:0]        out_byte_r;
  logic [15:0]       out_len_r;

  logic [1:0]        lvl;
  logic [EW-1:0]     tl_ext, cap_ext;
  logic [PW-1:0]     eff_len, room, len;
  logic [WANT_W-1:0] want;
  logic [7:0]        run_byte;
  logic              emit_en, done, set_ovf, set_pregap, finish;
  logic              adv, fire, load;

  assign lvl     = eff_level(gap_level);
  assign tl_ext  = EW'(track_length);
  assign cap_ext = EW'({PW{1'b1}});
  assign eff_len = (tl_ext < cap_ext) ? PW'(tl_ext) : PW'(cap_ext);
  assign room    = (eff_len > pos_r) ? eff_len - pos_r : '0;

  always_comb begin
    emit_en    = 1'b0;
    run_byte   = BYTE_GAP;
    want       = '0;
    done       = 1'b0;
    set_ovf    = 1'b0;
    set_pregap = 1'b0;
    finish     = 1'b0;
    case (step_r)
      ST_PREGAP: begin
        if (item_r.is_finish) begin
          finish = 1'b1;
          done   = 1'b1;
        end else begin
          emit_en    = !pregap_done_r;
          want       = pregap_len(lvl);
          set_pregap = 1'b1;
        end
      end
      ST_SYNC: begin
        if (ovf_r || (room == '0)) begin
          done = 1'b1;
        end else begin
          emit_en  = 1'b1;
          run_byte = BYTE_SYNC;
          want     = sync_len(lvl);
        end
      end
      ST_MCLK1: begin
        if (room < PW'(ID_ROOM)) begin
          set_ovf = 1'b1;
          done    = 1'b1;
        end else begin
          emit_en  = 1'b1;
          run_byte = BYTE_MCLK;
          want     = WANT_W'(3);
        end
      end
      ST_IDAM: begin
        emit_en  = 1'b1;
        run_byte = BYTE_IDAM;
        want     = WANT_W'(1);
      end
      ST_CYL: begin
        emit_en  = 1'b1;
        run_byte = item_r.cylinder;
        want     = WANT_W'(1);
      end
      ST_HEAD: begin
        emit_en  = 1'b1;
        run_byte = item_r.head;
        want     = WANT_W'(1);
      end
      ST_REC: begin
        emit_en  = 1'b1;
        run_byte = item_r.record;
        want     = WANT_W'(1);
      end
      ST_SIZE: begin
        emit_en  = 1'b1;
        run_byte = item_r.size_code;
        want     = WANT_W'(1);
      end
      ST_CRC1, ST_CRC2: begin
        emit_en  = 1'b1;
        run_byte = BYTE_CRC;
        want     = WANT_W'(1);
        done     = (step_r == ST_CRC2) ? 1'b0 : 1'b0;
      end
      ST_GAP2: begin
        emit_en  = 1'b1;
        want     = gap2_len(lvl);
        done     = item_r.no_data;
      end
      ST_MCLK2: begin
        if (room < PW'(DATA_ROOM)) begin
          set_ovf = 1'b1;
          done    = 1'b1;
        end else begin
          emit_en  = 1'b1;
          run_byte = BYTE_MCLK;
          want     = WANT_W'(3);
        end
      end
      ST_DAM: begin
        emit_en  = 1'b1;
        run_byte = BYTE_DAM;
        want     = WANT_W'(1);
      end
      ST_FILL: begin
        emit_en  = 1'b1;
        run_byte = BYTE_FILL;
        want     = WANT_W'(128) << item_r.size_code[1:0];
      end
      ST_GAP3: begin
        emit_en  = 1'b1;
        want     = gap3_len(lvl);
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign len     = (PW'(want) < room) ? PW'(want) : room;
  assign adv     = busy_r && (!out_valid_r || out_ready);
  assign fire    = adv && (finish || (emit_en && (len != '0)));
  assign q_ready = !busy_r || (adv && done);
  assign load    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= q_item;
    end
    if (fire) begin
      out_byte_r <= run_byte;
      out_len_r  <= finish ? 16'(room) : 16'(len);
      out_last_r <= finish;
      out_ovf_r  <= finish && ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      step_r        <= ST_PREGAP;
      pos_r         <= '0;
      pregap_done_r <= 1'b0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (adv) begin
        step_r <= done ? ST_PREGAP : step_r + 4'd1;
        if (finish) begin
          pos_r         <= '0;
          pregap_done_r <= 1'b0;
          ovf_r         <= 1'b0;
        end else begin
          if (fire) begin
            pos_r <= pos_r + len;
          end
          if (set_pregap) begin
            pregap_done_r <= 1'b1;
          end
          if (set_ovf) begin
            ovf_r <= 1'b1;
          end
        end
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (adv && done) begin
        busy_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fill_byte     = out_byte_r;
  assign out_run_length    = out_len_r;
  assign out_last_of_track = out_last_r;
  assign out_overflow      = out_ovf_r;
endmodule
`default_nettype wire

[hw/rtl/mfm_track_format_stream_generator.sv]
// Track format stream generator: turns a list of sector address marks into
// the run-length byte stream for a write-track command.
// Input channel (in_*): one item per sector ID (command 0) or a finish item
//   (command 1). A two-entry queue takes items while the back end still runs.
// Result channel (out_*): one (fill_byte, run_length) run per transfer; mark
//   items give up to fifteen runs, a finish item exactly one run with
//   last_of_track set and the overflow status of the whole track.
// Timing: the run sequencer walks one step a cycle while the result reg is
//   free; a mark item walks its steps in order (fewer with no data field or
//   on a missing room check; a finish item only its first); runs clipped to
//   zero still use a step. A first run passes item_r, then the result reg.
// Stall: a held result register stops the sequencer; the queue keeps
//   accepting until both entries are full, then in_ready drops.
// Reset (rst_n low, synchronous): queue empty, write position zero, pre-gap
//   pending, no overflow, gap_level 0, track_length 10416.
// Config (cfg_*): APB write at 0x0 gap_level, 0x4 track_length; write only
//   while no item is in flight.
`default_nettype none
`include "mfm_track_format_stream_generator_macros.svh"
module mfm_track_format_stream_generator #(
  parameter int TRACK_LEN_BITS = mfmtfg_pkg::TRACK_LEN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mfmtfg_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [7:0]                    in_cylinder,
  input  logic [7:0]                    in_head,
  input  logic [7:0]                    in_record,
  input  logic [7:0]                    in_size_code,
  input  logic                          in_no_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_fill_byte,
  output logic [15:0]                   out_run_length,
  output logic                          out_last_of_track,
  output logic                          out_overflow
);
  import mfmtfg_pkg::*;

  logic [1:0]   gap_level_r;
  logic [15:0]  track_len_r;
  logic         cfg_wr;
  logic         q_valid, q_ready;
  mfmtfg_item_t q_item;

  // Write on the access phase; no wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_level_r <= 2'd0;
      track_len_r <= TRACK_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_GAP_LEVEL: gap_level_r <= cfg_pwdata[1:0];
        REG_TRACK_LEN: track_len_r <= cfg_pwdata[15:0];
        default:       gap_level_r <= gap_level_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_GAP_LEVEL: cfg_prdata = {30'd0, gap_level_r};
      REG_TRACK_LEN: cfg_prdata = {16'd0, track_len_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Front: accept and classify items into the queue
  mfmtfg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_cylinder  (in_cylinder),
    .in_head      (in_head),
    .in_record    (in_record),
    .in_size_code (in_size_code),
    .in_no_data   (in_no_data),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  // Back: step through the runs of each item and hold the result register
  mfmtfg_back #(
    .TRACK_LEN_BITS (TRACK_LEN_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .gap_level         (gap_level_r),
    .track_length      (track_len_r),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fill_byte     (out_fill_byte),
    .out_run_length    (out_run_length),
    .out_last_of_track (out_last_of_track),
    .out_overflow      (out_overflow)
  );

  // Overflow is reported only on the closing run of a track
  `MFMTFG_ASSERT_SAME(a_ovf_on_last, out_valid && out_overflow, out_last_of_track)
  // Runs of mark items are never empty
  `MFMTFG_ASSERT_SAME(a_mark_run_nonzero, out_valid && !out_last_of_track,
                      out_run_length != 16'd0)
  // A full queue always offers an item to the back end
  `MFMTFG_ASSERT_SAME(a_full_queue_valid, !in_ready, q_valid)
  // The closing run carries the gap byte
  `MFMTFG_ASSERT_SAME(a_last_is_gap, out_valid && out_last_of_track,
                      out_fill_byte == BYTE_GAP)
endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import mfmtfg_pkg::*;

  // Position width of the block as built; the usable track length saturates here.
  localparam int LEN_BITS = TRACK_LEN_BITS_DEF;
  // A mark item walks up to 15 sequencer steps; first run via item_r, out_*_r.
  // Leave a comfortable margin for items that end without any run.
  localparam int SETTLE_CYCLES = 40;
  localparam int TOTAL_ITEMS   = 265;

  localparam logic CMD_MARK   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Gap lengths per effective gap level: pre-gap, sync, gap 2, gap 3.
  localparam int unsigned PREGAP_BY_LVL [3] = '{32, 24, 20};
  localparam int unsigned SYNC_BY_LVL   [3] = '{12, 10, 9};
  localparam int unsigned GAP2_BY_LVL   [3] = '{22, 16, 12};
  localparam int unsigned GAP3_BY_LVL   [3] = '{54, 48, 38};

  typedef enum logic [2:0] {
    DO_GAP,           // write gap_level with value
    DO_LEN,           // write track_length with value
    DO_MARK,          // send an address-mark item
    DO_FINISH,        // send a finish item, predicted
    DO_FINISH_EXPECT  // send a finish item; value and overflow are the known answer
  } plan_op_t;

  typedef struct packed {
    plan_op_t    op;
    logic [15:0] value;
    logic [7:0]  cylinder;
    logic [7:0]  head;
    logic [7:0]  record;
    logic [7:0]  size_code;
    logic        no_data;
    logic        overflow;
  } plan_row_t;

  typedef struct packed {
    logic [7:0]  fill_byte;
    logic [15:0] run_length;
    logic        last_of_track;
    logic        overflow;
  } track_run_t;

  // Directed part: reset state, field extremes, every gap level, and the
  // clipping, overflow and track-full corners with hand-worked finish results.
  localparam int PLAN_ROWS = 35;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{DO_FINISH_EXPECT, 16'd10416, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h00, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h12, 8'h01, 8'h02, 8'h02, 1'b1, 1'b0},
    '{DO_FINISH,        16'd0,     8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0},
    '{DO_GAP,           16'd1,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h01, 8'h00, 8'h01, 8'h03, 1'b0, 1'b0},
    '{DO_FINISH,        16'd0,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_GAP,           16'd2,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h02, 8'h01, 8'h05, 8'h01, 1'b0, 1'b0},
    '{DO_GAP,           16'd3,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h02, 8'h01, 8'h06, 8'h00, 1'b1, 1'b0},
    '{DO_MARK,          16'd0,     8'h02, 8'h01, 8'h07, 8'h02, 1'b0, 1'b0},
    // Lower the length below the position mid-track: nothing fits any more.
    '{DO_LEN,           16'd0,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h02, 8'h01, 8'h08, 8'h02, 1'b0, 1'b0},
    '{DO_FINISH_EXPECT, 16'd0,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    // Empty track: the pending pre-gap clips to nothing, no overflow.
    '{DO_MARK,          16'd0,     8'h03, 8'h00, 8'h01, 8'h02, 1'b0, 1'b0},
    '{DO_FINISH_EXPECT, 16'd0,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    // One byte short of the ID mark after sync, then a mark that is dropped.
    '{DO_LEN,           16'd37,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h04, 8'h00, 8'h01, 8'h02, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h04, 8'h00, 8'h02, 8'h02, 1'b0, 1'b0},
    '{DO_FINISH_EXPECT, 16'd8,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1},
    // ID mark fits exactly; gap 2 clips away and the data mark has no room.
    '{DO_LEN,           16'd38,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h05, 8'h00, 8'h01, 8'h02, 1'b0, 1'b0},
    '{DO_FINISH_EXPECT, 16'd0,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1},
    // Three bytes left after gap 2: one short of the data mark.
    '{DO_LEN,           16'd53,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h06, 8'h00, 8'h01, 8'h02, 1'b0, 1'b0},
    '{DO_FINISH_EXPECT, 16'd3,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1},
    // Filler clipped at the track end, then a mark on a full track.
    '{DO_GAP,           16'd0,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_LEN,           16'd300,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h07, 8'h00, 8'h01, 8'h03, 1'b0, 1'b0},
    '{DO_MARK,          16'd0,     8'h07, 8'h00, 8'h02, 8'h03, 1'b0, 1'b0},
    '{DO_FINISH_EXPECT, 16'd0,     8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_LEN,           16'd65535, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
    '{DO_FINISH_EXPECT, 16'd65535, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic       in_command   = CMD_MARK;
  logic [7:0] in_cylinder  = '0;
  logic [7:0] in_head      = '0;
  logic [7:0] in_record    = '0;
  logic [7:0] in_size_code = '0;
  logic       in_no_data   = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_fill_byte;
  logic [15:0] out_run_length;
  logic        out_last_of_track;
  logic        out_overflow;

  // Shadow of the track state and registers, advanced on every accepted item.
  logic [1:0]  gap_sel        = 2'd0;
  logic [15:0] trk_len        = TRACK_LEN_RST;
  int unsigned track_pos      = 0;
  bit          pregap_written = 1'b0;
  bit          mark_lost      = 1'b0;
  track_run_t  expected_runs [$];

  // Handshake pacing knobs, retuned per track in the random part.
  bit rx_stalls = 1'b1;
  bit tx_quiet  = 1'b0;
  int rx_hold   = 0;
  int rx_roll;

  int errors          = 0;
  int runs_checked    = 0;
  int items_sent      = 0;
  int productive_items = 0;
  int tracks_finished = 0;
  int tracks_lost     = 0;
  track_run_t oldest_run;

  mfm_track_format_stream_generator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_cylinder       (in_cylinder),
    .in_head           (in_head),
    .in_record         (in_record),
    .in_size_code      (in_size_code),
    .in_no_data        (in_no_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fill_byte     (out_fill_byte),
    .out_run_length    (out_run_length),
    .out_last_of_track (out_last_of_track),
    .out_overflow      (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Room left on the track, with the length saturated to the position width.
  function automatic int unsigned room_on_track();
    int unsigned lim;
    lim = (trk_len > (2 ** LEN_BITS - 1)) ? (2 ** LEN_BITS - 1) : trk_len;
    return (lim > track_pos) ? lim - track_pos : 0;
  endfunction

  // Clip a run to the room left; drop it if nothing remains.
  function automatic void add_run(input logic [7:0] fill, input int unsigned want);
    int unsigned len;
    len = (want < room_on_track()) ? want : room_on_track();
    if (len != 0) begin
      expected_runs.push_back('{fill, 16'(len), 1'b0, 1'b0});
      track_pos += len;
    end
  endfunction

  // Expand one accepted item into the runs the track stream should carry.
  function automatic void predict_track_runs(input mfmtfg_item_t it);
    int unsigned lvl;
    lvl = (gap_sel > 2'd2) ? 2 : gap_sel;
    if (it.is_finish == CMD_FINISH) begin
      // Pad the rest of the track, report status, and start a fresh track.
      expected_runs.push_back('{BYTE_GAP, 16'(room_on_track()), 1'b1, mark_lost});
      tracks_finished++;
      if (mark_lost) tracks_lost++;
      track_pos      = 0;
      pregap_written = 1'b0;
      mark_lost      = 1'b0;
      return;
    end
    if (!pregap_written) begin
      add_run(BYTE_GAP, PREGAP_BY_LVL[lvl]);
      pregap_written = 1'b1;
    end
    if (mark_lost || room_on_track() == 0) return;
    add_run(BYTE_SYNC, SYNC_BY_LVL[lvl]);
    if (room_on_track() < ID_ROOM) begin
      mark_lost = 1'b1;
      return;
    end
    add_run(BYTE_MCLK, 3);
    add_run(BYTE_IDAM, 1);
    add_run(it.cylinder, 1);
    add_run(it.head, 1);
    add_run(it.record, 1);
    add_run(it.size_code, 1);
    add_run(BYTE_CRC, 1);
    add_run(BYTE_GAP, GAP2_BY_LVL[lvl]);
    if (!it.no_data) begin
      if (room_on_track() < DATA_ROOM) begin
        mark_lost = 1'b1;
        return;
      end
      add_run(BYTE_MCLK, 3);
      add_run(BYTE_DAM, 1);
      add_run(BYTE_FILL, 128 << it.size_code[1:0]);
      add_run(BYTE_CRC, 1);
      add_run(BYTE_GAP, GAP3_BY_LVL[lvl]);
    end
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_quiet || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item and hold it until the block takes it. Call right after
  // a rising edge; returns at the edge that accepted the item.
  task automatic send_item(input mfmtfg_item_t it, input int gap);
    int queued;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= it.is_finish;
    in_cylinder  <= it.cylinder;
    in_head      <= it.head;
    in_record    <= it.record;
    in_size_code <= it.size_code;
    in_no_data   <= it.no_data;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    queued = expected_runs.size();
    predict_track_runs(it);
    if (expected_runs.size() != queued) productive_items++;
  endtask

  // Drop valid and hold until every predicted run is back; optionally let the
  // sequencer run out items that produce no runs at all.
  task automatic wait_idle(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_runs.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value on the edge
  // where the access completes.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_GAP_LEVEL) gap_sel = val[1:0];
    else trk_len = val[15:0];
    @(posedge clk);
  endtask

  // Result side back-pressure: single-cycle drops plus the odd long hold.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else if (!rx_stalls) begin
      out_ready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 25) begin
        out_ready <= 1'b0;
      end else if (rx_roll < 28) begin
        out_ready <= 1'b0;
        rx_hold   <= $urandom_range(4, 40);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Score every accepted run against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected run: byte %h len %0d last %b ovf %b", $time,
                 out_fill_byte, out_run_length, out_last_of_track, out_overflow);
        errors++;
      end else begin
        oldest_run = expected_runs.pop_front();
        if (oldest_run.fill_byte != out_fill_byte ||
            oldest_run.run_length != out_run_length ||
            oldest_run.last_of_track != out_last_of_track ||
            oldest_run.overflow != out_overflow) begin
          $display("%0t: run mismatch: expected byte %h len %0d last %b ovf %b", $time,
                   oldest_run.fill_byte, oldest_run.run_length,
                   oldest_run.last_of_track, oldest_run.overflow);
          $display("%0t:               actual   byte %h len %0d last %b ovf %b", $time,
                   out_fill_byte, out_run_length, out_last_of_track, out_overflow);
          errors++;
        end
        runs_checked++;
      end
    end
  end

  initial begin
    plan_row_t    row;
    mfmtfg_item_t item;
    int           sectors;
    int           roll;
    logic [7:0]   cyl;
    logic [7:0]   side;
    logic [7:0]   sz;
    logic [15:0]  new_len;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan; hold configuration writes until the block is idle.
    for (int k = 0; k < PLAN_ROWS; k++) begin
      row = DIRECTED_PLAN[k];
      case (row.op)
        DO_GAP: begin
          wait_idle(1'b1);
          write_reg(REG_GAP_LEVEL, 32'(row.value));
        end
        DO_LEN: begin
          wait_idle(1'b1);
          write_reg(REG_TRACK_LEN, 32'(row.value));
        end
        default: begin
          item = '{(row.op == DO_MARK) ? CMD_MARK : CMD_FINISH, row.cylinder, row.head,
                   row.record, row.size_code, row.no_data};
          send_item(item, pick_gap());
          // Swap in the hand-worked answer for the finish run just queued.
          if (row.op == DO_FINISH_EXPECT)
            expected_runs[expected_runs.size() - 1] = '{BYTE_GAP, row.value, 1'b1, row.overflow};
        end
      endcase
    end

    // Random tracks: well-formed sector lists with random content, a sprinkle
    // of noise items, and length changes mid-track.
    while (items_sent < TOTAL_ITEMS) begin
      wait_idle(1'b1);
      if ($urandom_range(0, 9) < 7) write_reg(REG_GAP_LEVEL, $urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 45)      new_len = 16'd10416;
      else if (roll < 60) new_len = 16'($urandom_range(0, 400));
      else if (roll < 75) new_len = 16'($urandom_range(400, 12000));
      else if (roll < 85) new_len = 16'hFFFF;
      else if (roll < 90) new_len = 16'd0;
      else                new_len = 16'($urandom_range(0, 65535));
      write_reg(REG_TRACK_LEN, 32'(new_len));

      rx_stalls = ($urandom_range(0, 3) != 0);
      tx_quiet  = ($urandom_range(0, 3) == 0);
      sectors   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(1, 12);
      cyl       = 8'($urandom_range(0, 255));
      side      = 8'($urandom_range(0, 1));
      sz        = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 3));

      for (int s = 0; s < sectors; s++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          // Change the length while the track is half built.
          wait_idle(1'b1);
          write_reg(REG_TRACK_LEN, $urandom_range(0, 65535));
        end else if (roll < 8) begin
          // Hold the sender until the stream has fully drained.
          wait_idle(1'b0);
        end
        item.is_finish = CMD_MARK;
        item.cylinder  = cyl;
        item.head      = side;
        item.record    = 8'(s + 1);
        item.size_code = sz;
        item.no_data   = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) == 0) begin
          item.cylinder  = 8'($urandom_range(0, 255));
          item.head      = 8'($urandom_range(0, 255));
          item.record    = 8'($urandom_range(0, 255));
          item.size_code = 8'($urandom_range(0, 255));
        end
        send_item(item, pick_gap());
      end

      item.is_finish = CMD_FINISH;
      item.cylinder  = 8'($urandom_range(0, 255));
      item.head      = 8'($urandom_range(0, 255));
      item.record    = 8'($urandom_range(0, 255));
      item.size_code = 8'($urandom_range(0, 255));
      item.no_data   = 1'($urandom_range(0, 1));
      send_item(item, pick_gap());
    end

    wait_idle(1'b1);
    $display("Formatted %0d tracks (%0d with a mark that did not fit) from %0d items, %0d with runs.",
             tracks_finished, tracks_lost, items_sent, productive_items);
    $display("Compared %0d runs over gap levels 0 to 3 and lengths from empty to full width.",
             runs_checked);
    if (errors == 0 && expected_runs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
